FILE: rtl/dpds_pkg.sv
// Package for the digit pattern divisor sieve.
// Widths, table sizes, request codes and the multiplier bit pattern.
// No dependencies.
package dpds_pkg;
	localparam int VAL_W        = 48;
	localparam int DIGIT_W      = 10;
	localparam int ENTRIES      = 24;
	localparam int ENTRY_IDX_W  = 5;
	localparam int ROWS         = 1024;
	localparam int ROW_ADDR_W   = 10;
	localparam int PAIRS        = 81;
	localparam int PAIR_IDX_W   = 7;
	localparam int MAX_RESULTS  = 36;
	localparam int RES_CNT_W    = 6;
	localparam int DIGIT_SEL_W  = 4;

	localparam logic [DIGIT_W-1:0]     SCAN_FROM_RESET   = 10'd20;
	localparam logic [DIGIT_W-1:0]     LAST_DIGIT        = 10'(ROWS - 1);
	localparam logic [3:0]             TEN_BITS          = 4'b1010;
	localparam logic [DIGIT_SEL_W-1:0] DIGIT_ONE         = 4'd1;
	localparam logic [DIGIT_SEL_W-1:0] DIGIT_NINE        = 4'd9;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [PAIRS-1:0] row_t;

	// (x + y) mod m for x, y below m
	function automatic val_t add_wrap(input val_t x, input val_t y, input val_t m);
		logic [VAL_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[VAL_W-1:0];
	endfunction
endpackage

FILE: rtl/dpds_pow_step.sv
// Bit-serial modular multiply by ten: result = (10 * power) mod prime.
// Each multiplier bit has a doubling step and an add step, each a single add and compare. Uses dpds_pkg.
module dpds_pow_step import dpds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  val_t power,
	input  val_t prime,
	output logic done,
	output val_t result
);
	logic [2:0] step_q;
	logic       busy_q;
	val_t       acc_q;
	logic       bit_sel;

	assign bit_sel = TEN_BITS[2'(3 - step_q[2:1])];
	assign done    = busy_q && step_q == 3'd7;
	assign result  = (bit_sel && step_q[0]) ? add_wrap(acc_q, power, prime) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			acc_q <= '0;
		else if (busy_q) begin
			if (!step_q[0])
				acc_q <= add_wrap(acc_q, acc_q, prime);
			else if (bit_sel)
				acc_q <= add_wrap(acc_q, power, prime);
		end
	end
endmodule

FILE: rtl/dpds_found_mem.sv
// Found map: one 81-bit row of pair marks per digit count.
// One write port, one registered read port. Uses dpds_pkg.
module dpds_found_mem import dpds_pkg::*; (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ROW_ADDR_W-1:0] waddr,
	input  row_t                  wdata,
	input  logic [ROW_ADDR_W-1:0] raddr,
	output row_t                  rdata
);
	row_t mem [ROWS];
	row_t rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end
endmodule

FILE: rtl/digit_pattern_divisor_sieve.sv
// Top level of the digit pattern divisor sieve: control, residue table, pair scan.
// Uses dpds_pkg, dpds_pow_step and dpds_found_mem.
//
// After reset the block clears all 1024 rows of its found map with in_stall high.
// Load and start transfers finish in the idle state, as does a tick with a zero prime
// or with the digit count already at its last value. Any other tick runs the power
// update in ST_POW (a doubling and an add step per bit of the multiplier ten); below
// the start digit that is all. At or above it the row is read, the residue entries are
// scanned and the 81 digit pairs of each entry equal to the power walked, with a step
// per lead digit; a result waiting on a stalled output holds the pair walk and flush.
module digit_pattern_divisor_sieve import dpds_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [DIGIT_W-1:0]     cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             req_type,
	input  logic [ENTRY_IDX_W-1:0] entry_index,
	input  logic [VAL_W-1:0]       entry_value,
	input  logic [VAL_W-1:0]       prime_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [DIGIT_W-1:0]     digit_count,
	output logic [3:0]             lead_digit,
	output logic [3:0]             tail_digit,
	output logic [VAL_W-1:0]       divisor,
	output logic                   last_of_run
);
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_POW   = 4'd2;
	localparam logic [3:0] ST_RDROW = 4'd3;
	localparam logic [3:0] ST_SCAN  = 4'd4;
	localparam logic [3:0] ST_PAIR  = 4'd5;
	localparam logic [3:0] ST_NEXTA = 4'd6;
	localparam logic [3:0] ST_FLUSH = 4'd7;

	logic [3:0]             state_q;
	logic [ROW_ADDR_W-1:0]  clr_addr_q;
	logic [DIGIT_W-1:0]     scan_from_q;
	val_t                   table_q [ENTRIES];
	val_t                   prime_q;
	val_t                   power_q;
	logic [DIGIT_W-1:0]     digit_q;
	logic [ENTRY_IDX_W-1:0] scan_i_q;
	logic [DIGIT_SEL_W-1:0] a_q;
	logic [DIGIT_SEL_W-1:0] b_q;
	logic [PAIR_IDX_W-1:0]  pair_idx_q;
	val_t                   ra_q;
	val_t                   t_q;
	row_t                   row_q;
	logic [RES_CNT_W-1:0]   n_q;
	logic                   pend_valid_q;
	logic [DIGIT_SEL_W-1:0] pend_a_q;
	logic [DIGIT_SEL_W-1:0] pend_b_q;
	logic                   out_valid_q;
	logic [DIGIT_W-1:0]     out_d_q;
	logic [3:0]             out_a_q;
	logic [3:0]             out_b_q;
	val_t                   out_p_q;
	logic                   out_last_q;

	logic  in_xfer;
	logic  out_free;
	logic  out_load;
	logic  pow_start;
	logic  pow_done;
	val_t  pow_result;
	logic  mem_we;
	logic [ROW_ADDR_W-1:0] mem_waddr;
	row_t  mem_wdata;
	row_t  mem_rdata;
	logic  hit;
	logic  pair_go;
	logic  scan_end;
	logic  scan_eq;
	logic  flush_go;
	val_t  entry_v;

	assign in_stall = state_q != ST_IDLE;
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign pow_start = in_xfer && req_type == REQ_TICK && digit_q < LAST_DIGIT
		&& prime_q != '0;

	assign entry_v  = (scan_i_q < ENTRY_IDX_W'(ENTRIES)) ? table_q[scan_i_q] : '0;
	assign scan_end = scan_i_q == ENTRY_IDX_W'(ENTRIES) || entry_v > power_q;
	assign scan_eq  = entry_v == power_q;

	assign hit     = t_q == '0 && !row_q[pair_idx_q] && n_q < RES_CNT_W'(MAX_RESULTS);
	assign pair_go = !(hit && pend_valid_q && !out_free);
	assign flush_go = !pend_valid_q || out_free;
	assign out_load = pend_valid_q && ((state_q == ST_PAIR && pair_go && hit)
		|| (state_q == ST_FLUSH && flush_go));

	assign mem_we    = state_q == ST_CLEAR || (state_q == ST_FLUSH && flush_go);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : digit_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : row_q;

	dpds_pow_step u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pow_start),
		.power  (power_q),
		.prime  (prime_q),
		.done   (pow_done),
		.result (pow_result)
	);

	dpds_found_mem u_found (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (digit_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_from_q <= SCAN_FROM_RESET;
		end else if (cfg_wr_en) begin
			scan_from_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && req_type == REQ_LOAD && entry_index < ENTRY_IDX_W'(ENTRIES))
			table_q[entry_index] <= entry_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			prime_q      <= '0;
			power_q      <= VAL_W'(1);
			digit_q      <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ROW_ADDR_W'(1);
					if (clr_addr_q == ROW_ADDR_W'(ROWS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_xfer && req_type == REQ_START) begin
						prime_q <= prime_value;
						power_q <= VAL_W'(1);
						digit_q <= '0;
					end else if (in_xfer && req_type == REQ_TICK && digit_q < LAST_DIGIT) begin
						digit_q <= digit_q + DIGIT_W'(1);
						if (prime_q == '0)
							power_q <= '0;
						else
							state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (pow_done) begin
						power_q <= pow_result;
						if (digit_q < scan_from_q)
							state_q <= ST_IDLE;
						else
							state_q <= ST_RDROW;
					end
				end
				ST_RDROW: begin
					scan_i_q <= '0;
					n_q      <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_FLUSH;
					end else if (!scan_eq) begin
						scan_i_q <= scan_i_q + ENTRY_IDX_W'(1);
					end else begin
						a_q        <= DIGIT_ONE;
						b_q        <= DIGIT_ONE;
						pair_idx_q <= '0;
						ra_q       <= power_q;
						t_q        <= add_wrap(power_q, VAL_W'(1), prime_q);
						state_q    <= ST_PAIR;
					end
				end
				ST_PAIR: begin
					if (pair_go) begin
						if (hit) begin
							n_q          <= n_q + RES_CNT_W'(1);
							pend_valid_q <= 1'b1;
							pend_a_q     <= a_q;
							pend_b_q     <= b_q;
							if (pend_valid_q) begin
								out_d_q     <= digit_q;
								out_a_q     <= pend_a_q;
								out_b_q     <= pend_b_q;
								out_p_q     <= prime_q;
								out_last_q  <= 1'b0;
							end
						end
						pair_idx_q <= pair_idx_q + PAIR_IDX_W'(1);
						if (b_q != DIGIT_NINE) begin
							b_q <= b_q + DIGIT_ONE;
							t_q <= add_wrap(t_q, VAL_W'(1), prime_q);
						end else if (a_q != DIGIT_NINE) begin
							a_q     <= a_q + DIGIT_ONE;
							b_q     <= DIGIT_ONE;
							ra_q    <= add_wrap(ra_q, power_q, prime_q);
							state_q <= ST_NEXTA;
						end else begin
							scan_i_q <= scan_i_q + ENTRY_IDX_W'(1);
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_NEXTA: begin
					t_q     <= add_wrap(ra_q, VAL_W'(1), prime_q);
					state_q <= ST_PAIR;
				end
				ST_FLUSH: begin
					if (flush_go) begin
						if (pend_valid_q) begin
							pend_valid_q <= 1'b0;
							out_d_q      <= digit_q;
							out_a_q      <= pend_a_q;
							out_b_q      <= pend_b_q;
							out_p_q      <= prime_q;
							out_last_q   <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RDROW)
			row_q <= mem_rdata;
		else if (state_q == ST_PAIR && pair_go && hit)
			row_q[pair_idx_q] <= 1'b1;
	end

	assign out_valid   = out_valid_q;
	assign digit_count = out_d_q;
	assign lead_digit  = out_a_q;
	assign tail_digit  = out_b_q;
	assign divisor     = out_p_q;
	assign last_of_run = out_last_q;

	a_out_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lead_digit >= 4'd1 && lead_digit <= 4'd9
			&& tail_digit >= 4'd1 && tail_digit <= 4'd9)
		else $error("result digit out of range");

	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> n_q != '0 && n_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("pending result without count");

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall)
		else $error("input taken during found map sweep");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("result left pending after tick");
endmodule
